// ===== src/smef_pkg.sv =====
`timescale 1ns / 1ps

package smef_pkg;

    localparam int CFG_INDEX_BITS = 1;
    localparam int CFG_DATA_BITS  = 9;
    localparam int WL_BITS        = 4;
    localparam int ALPHA_BITS     = 9;
    localparam int ALPHA_ONE      = 256;

    localparam logic [CFG_INDEX_BITS-1:0] REG_WINDOW_LENGTH = 1'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_ALPHA         = 1'd1;

    localparam logic [WL_BITS-1:0]    WL_RESET    = 4'd5;
    localparam logic [ALPHA_BITS-1:0] ALPHA_RESET = 9'd51;

    typedef struct packed {
        logic lo;
        logic hi;
    } smef_hit_t;

endpackage

// ===== src/sliding_median_and_ema_filter_core.sv =====
`timescale 1ns / 1ps
// Flow: an accepted beat passes the cell row, the rank registers and then the output register.
// Throughput: one beat per cycle unless out_stall holds the pipeline; the cell row, the rank registers and the
// output register form a three-stage pipeline that stalls stage by stage.
// Reset (rst_n, async, active low) clears fill count, pipeline valids, the
// lowpass history and restores window_length = 5 and alpha = 51.

module sliding_median_and_ema_filter_core
    import smef_pkg::*;
#(
    parameter int MAX_WINDOW  = 8,
    parameter int SAMPLE_BITS = 16
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_write_en,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic [SAMPLE_BITS-1:0]    sample,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic [SAMPLE_BITS-1:0]    median_value,
    output logic [SAMPLE_BITS-1:0]    smoothed_value
);

    localparam int CW = $clog2(MAX_WINDOW + 1);

    logic [WL_BITS-1:0]    wl_reg;
    logic [ALPHA_BITS-1:0] alpha_reg;
    logic [CW-1:0]         fill_count_reg;
    logic [CW-1:0]         count0_reg;
    logic                  v0_reg;
    logic                  v1_reg;
    logic                  out_valid_reg;
    logic [SAMPLE_BITS-1:0] median_reg;
    logic [SAMPLE_BITS-1:0] smoothed_reg;

    logic [CW-1:0]         wl_eff;
    logic [ALPHA_BITS-1:0] alpha_eff;
    logic [CW-1:0]         fill_next;
    logic [CW-1:0]         count_next;
    logic [CW-1:0]         lo_pos;
    logic [CW-1:0]         hi_pos;

    logic in_accept;
    logic out_ready;
    logic s1_move;
    logic s1_ready;
    logic s0_move;
    logic s0_ready;

    logic [MAX_WINDOW-1:0][SAMPLE_BITS-1:0] win;
    logic [MAX_WINDOW-1:0][SAMPLE_BITS-1:0] held;
    smef_hit_t [MAX_WINDOW-1:0]             hits;
    logic [MAX_WINDOW-1:0]                  hit_lo_vec;
    logic [MAX_WINDOW-1:0]                  hit_hi_vec;

    logic [SAMPLE_BITS-1:0] lo_val;
    logic [SAMPLE_BITS-1:0] hi_val;
    logic [SAMPLE_BITS:0]   med_sum;
    logic [SAMPLE_BITS-1:0] y;

    // handshake and stage advance
    assign out_ready = !out_valid_reg || !out_stall;
    assign s1_move   = v1_reg && out_ready;
    assign s1_ready  = !v1_reg || out_ready;
    assign s0_move   = v0_reg && s1_ready;
    assign s0_ready  = !v0_reg || s1_ready;
    assign in_stall  = !s0_ready;
    assign in_accept = in_valid && !in_stall;

    always_comb
    begin
        if (wl_reg == '0)
        begin
            wl_eff = CW'(1);
        end
        else if (int'(wl_reg) > MAX_WINDOW)
        begin
            wl_eff = CW'(MAX_WINDOW);
        end
        else
        begin
            wl_eff = CW'(wl_reg);
        end
    end

    assign alpha_eff  = (alpha_reg > ALPHA_BITS'(ALPHA_ONE)) ? ALPHA_BITS'(ALPHA_ONE)
                                                             : alpha_reg;
    assign fill_next  = (fill_count_reg == CW'(MAX_WINDOW)) ? fill_count_reg
                                                            : fill_count_reg + CW'(1);
    assign count_next = (fill_next < wl_eff) ? fill_next : wl_eff;
    assign lo_pos     = (count0_reg - CW'(1)) >> 1;
    assign hi_pos     = count0_reg >> 1;

    // cell row: cell 0 holds the newest sample
    for (genvar i = 0; i < MAX_WINDOW; i++)
    begin : g_cell
        smef_cell #(
            .SAMPLE_BITS (SAMPLE_BITS),
            .MAX_WINDOW  (MAX_WINDOW),
            .CELL_INDEX  (i)
        ) u_cell (
            .clk      (clk),
            .shift_en (in_accept),
            .shift_in ((i == 0) ? sample : win[(i == 0) ? 0 : i - 1]),
            .value    (win[i]),
            .eval_en  (s0_move),
            .window   (win),
            .count    (count0_reg),
            .lo_pos   (lo_pos),
            .hi_pos   (hi_pos),
            .hit      (hits[i]),
            .held     (held[i])
        );
        assign hit_lo_vec[i] = hits[i].lo;
        assign hit_hi_vec[i] = hits[i].hi;
    end

    always_comb
    begin
        lo_val = '0;
        hi_val = '0;
        for (int i = 0; i < MAX_WINDOW; i++)
        begin
            lo_val = lo_val | (held[i] & {SAMPLE_BITS{hit_lo_vec[i]}});
            hi_val = hi_val | (held[i] & {SAMPLE_BITS{hit_hi_vec[i]}});
        end
    end

    assign med_sum = {lo_val[SAMPLE_BITS-1], lo_val} + {hi_val[SAMPLE_BITS-1], hi_val};

    smef_ema #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_ema (
        .clk       (clk),
        .rst_n     (rst_n),
        .load_en   (s0_move),
        .x         (win[0]),
        .alpha_eff (alpha_eff),
        .step_en   (s1_move),
        .y         (y)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wl_reg         <= WL_RESET;
            alpha_reg      <= ALPHA_RESET;
            fill_count_reg <= '0;
            count0_reg     <= '0;
            v0_reg         <= 1'b0;
            v1_reg         <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_write_en)
            begin
                unique case (cfg_index)
                    REG_WINDOW_LENGTH: wl_reg    <= cfg_data[WL_BITS-1:0];
                    REG_ALPHA:         alpha_reg <= cfg_data[ALPHA_BITS-1:0];
                    default:           ;
                endcase
            end
            if (in_accept)
            begin
                fill_count_reg <= fill_next;
                count0_reg     <= count_next;
                v0_reg         <= 1'b1;
            end
            else if (s0_move)
            begin
                v0_reg <= 1'b0;
            end
            if (s0_move)
            begin
                v1_reg <= 1'b1;
            end
            else if (s1_move)
            begin
                v1_reg <= 1'b0;
            end
            if (s1_move)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_move)
        begin
            median_reg   <= med_sum[SAMPLE_BITS:1];
            smoothed_reg <= y;
        end
    end

    assign out_valid      = out_valid_reg;
    assign median_value   = median_reg;
    assign smoothed_value = smoothed_reg;

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_count_reg <= CW'(MAX_WINDOW))
        else $error("fill count above window depth");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        v0_reg |-> (count0_reg != '0 && count0_reg <= fill_count_reg))
        else $error("median count out of range");

    a_accept_loads: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> v0_reg)
        else $error("accepted beat not held in cell row");

    a_one_lo: assert property (@(posedge clk) disable iff (!rst_n)
        v1_reg |-> ($onehot(hit_lo_vec) && $onehot(hit_hi_vec)))
        else $error("median select not unique");

    a_move_fills: assert property (@(posedge clk) disable iff (!rst_n)
        s1_move |=> out_valid_reg)
        else $error("result lost at output register");

endmodule

// ===== src/smef_cell.sv =====
`timescale 1ns / 1ps

module smef_cell
    import smef_pkg::*;
#(
    parameter int SAMPLE_BITS = 16,
    parameter int MAX_WINDOW  = 8,
    parameter int CELL_INDEX  = 0,
    localparam int CW         = $clog2(MAX_WINDOW + 1)
)
(
    input  logic                                  clk,
    input  logic                                  shift_en,
    input  logic [SAMPLE_BITS-1:0]                shift_in,
    output logic [SAMPLE_BITS-1:0]                value,
    input  logic                                  eval_en,
    input  logic [MAX_WINDOW-1:0][SAMPLE_BITS-1:0] window,
    input  logic [CW-1:0]                         count,
    input  logic [CW-1:0]                         lo_pos,
    input  logic [CW-1:0]                         hi_pos,
    output smef_hit_t                             hit,
    output logic [SAMPLE_BITS-1:0]                held
);

    logic [SAMPLE_BITS-1:0] sample_reg;
    logic [SAMPLE_BITS-1:0] held_reg;
    smef_hit_t              hit_reg;
    smef_hit_t              hit_next;
    logic [CW-1:0]          rank;
    logic                   in_win;

    // rank among the in-window samples; ties broken by age
    always_comb
    begin
        rank = '0;
        for (int j = 0; j < MAX_WINDOW; j++)
        begin
            if (j != CELL_INDEX && CW'(j) < count)
            begin
                if ($signed(window[j]) < $signed(sample_reg) ||
                    (window[j] == sample_reg && j < CELL_INDEX))
                begin
                    rank = rank + CW'(1);
                end
            end
        end
    end

    assign in_win      = CW'(CELL_INDEX) < count;
    assign hit_next.lo = in_win && (rank == lo_pos);
    assign hit_next.hi = in_win && (rank == hi_pos);

    always_ff @(posedge clk)
    begin
        if (shift_en)
        begin
            sample_reg <= shift_in;
        end
        if (eval_en)
        begin
            hit_reg  <= hit_next;
            held_reg <= sample_reg;
        end
    end

    assign value = sample_reg;
    assign hit   = hit_reg;
    assign held  = held_reg;

endmodule

// ===== src/smef_ema.sv =====
`timescale 1ns / 1ps

module smef_ema
    import smef_pkg::*;
#(
    parameter int SAMPLE_BITS = 16
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   load_en,
    input  logic [SAMPLE_BITS-1:0] x,
    input  logic [ALPHA_BITS-1:0]  alpha_eff,
    input  logic                   step_en,
    output logic [SAMPLE_BITS-1:0] y
);

    logic signed [SAMPLE_BITS+9:0]  ax_reg;
    logic signed [SAMPLE_BITS-1:0]  y_prev_reg;
    logic        [ALPHA_BITS-1:0]   beta;
    logic signed [SAMPLE_BITS+9:0]  prod;
    logic signed [SAMPLE_BITS+10:0] acc;

    assign beta = ALPHA_BITS'(ALPHA_ONE) - alpha_eff;
    assign prod = $signed({1'b0, beta}) * y_prev_reg;
    assign acc  = (SAMPLE_BITS+11)'(ax_reg) + (SAMPLE_BITS+11)'(prod);
    assign y    = acc[SAMPLE_BITS+7:8];

    always_ff @(posedge clk)
    begin
        if (load_en)
        begin
            ax_reg <= $signed({1'b0, alpha_eff}) * $signed(x);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            y_prev_reg <= '0;
        end
        else if (step_en)
        begin
            y_prev_reg <= y;
        end
    end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
    import smef_pkg::*;

    localparam int SBITS       = 16;
    localparam int WIN_MAX     = 8;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic [SBITS-1:0] median;
        logic [SBITS-1:0] smooth;
    } filt_out_t;

    logic                      clk          = 1'b0;
    logic                      rst_n        = 1'b0;
    logic                      cfg_write_en = 1'b0;
    logic [CFG_INDEX_BITS-1:0] cfg_index    = '0;
    logic [CFG_DATA_BITS-1:0]  cfg_data     = '0;
    logic                      in_valid     = 1'b0;
    logic                      in_stall;
    logic [SBITS-1:0]          sample       = '0;
    logic                      out_valid;
    logic                      out_stall    = 1'b0;
    logic [SBITS-1:0]          median_value;
    logic [SBITS-1:0]          smoothed_value;

    // predictor state
    logic [WL_BITS-1:0]      wl_reg    = WL_RESET;
    logic [ALPHA_BITS-1:0]   alpha_reg = ALPHA_RESET;
    logic signed [SBITS-1:0] ring [WIN_MAX];
    int                      ring_fill = 0;
    int                      ring_head = 0;
    logic signed [SBITS-1:0] lp_prev   = '0;
    filt_out_t               pending_filtered[$];

    int err_cnt       = 0;
    int cycle_cnt     = 0;
    int in_idle_pct   = 0;
    int out_stall_pct = 0;
    int hold_len      = 0;
    int hold_seq      = 0;
    int hold_seen     = 0;
    int hold_cnt      = 0;

    sliding_median_and_ema_filter_core #(
        .MAX_WINDOW  (WIN_MAX),
        .SAMPLE_BITS (SBITS)
    ) i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .sample         (sample),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .median_value   (median_value),
        .smoothed_value (smoothed_value)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    function automatic filt_out_t filter_sample(logic signed [SBITS-1:0] x);
        logic signed [SBITS-1:0] sorted [WIN_MAX];
        logic signed [SBITS-1:0] key;
        logic signed [SBITS:0]   pair_sum;
        longint                  acc;
        int                      span;
        int                      count;
        int                      a_eff;
        int                      slot;
        int                      i;
        int                      j;
        filt_out_t               r;

        span  = (wl_reg == 0) ? 1 : ((wl_reg > WIN_MAX) ? WIN_MAX : int'(wl_reg));
        a_eff = (alpha_reg > ALPHA_ONE) ? ALPHA_ONE : int'(alpha_reg);

        ring[ring_head] = x;
        ring_head = (ring_head + 1) % WIN_MAX;
        if (ring_fill < WIN_MAX)
            ring_fill++;
        count = (ring_fill < span) ? ring_fill : span;

        slot = ring_head;
        for (i = 0; i < count; i++)
        begin
            slot = (slot == 0) ? WIN_MAX - 1 : slot - 1;
            sorted[i] = ring[slot];
        end
        for (i = 1; i < count; i++)
        begin
            key = sorted[i];
            j = i;
            while (j > 0 && sorted[j-1] > key)
            begin
                sorted[j] = sorted[j-1];
                j--;
            end
            sorted[j] = key;
        end

        if (count % 2 == 1)
            r.median = sorted[count/2];
        else
        begin
            pair_sum = sorted[count/2-1] + sorted[count/2];
            r.median = pair_sum[SBITS:1];
        end

        acc = longint'(a_eff) * longint'(x) + longint'(ALPHA_ONE - a_eff) * longint'(lp_prev);
        acc = acc >>> 8;
        lp_prev  = acc[SBITS-1:0];
        r.smooth = lp_prev;
        return r;
    endfunction

    function automatic logic [SBITS-1:0] rand_sample();
        case ($urandom_range(9))
            0: return 16'h7fff;
            1: return 16'h8000;
            2, 3: return SBITS'($urandom_range(15)) - 16'd8;
            default: return SBITS'($urandom);
        endcase
    endfunction

    task automatic set_config(input logic [WL_BITS-1:0] wl, input logic [ALPHA_BITS-1:0] a);
        logic [CFG_DATA_BITS-WL_BITS-1:0] hi_bits;
        hi_bits = (CFG_DATA_BITS-WL_BITS)'($urandom);
        cfg_write_en <= 1'b1;
        cfg_index    <= REG_WINDOW_LENGTH;
        cfg_data     <= {hi_bits, wl};
        @(posedge clk);
        wl_reg = wl;
        cfg_index <= REG_ALPHA;
        cfg_data  <= a;
        @(posedge clk);
        alpha_reg = a;
        cfg_write_en <= 1'b0;
    endtask

    task automatic set_traffic(input int idle_pct, input int stall_pct);
        in_idle_pct   = idle_pct;
        out_stall_pct = stall_pct;
    endtask

    task automatic send_sample(input logic [SBITS-1:0] s);
        filt_out_t beat_want;
        if (in_idle_pct > 0 && $urandom_range(99) < in_idle_pct)
        begin
            in_valid <= 1'b0;
            sample   <= SBITS'($urandom);
            do
                @(posedge clk);
            while ($urandom_range(99) < in_idle_pct);
        end
        in_valid <= 1'b1;
        sample   <= s;
        do
            @(posedge clk);
        while (in_stall);
        beat_want = filter_sample(s);
        pending_filtered.insert(pending_filtered.size(), beat_want);
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (pending_filtered.size() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    task automatic test_reset_defaults();
        set_traffic(0, 0);
        send_sample(16'h7fff);
        send_sample(16'h8000);
        send_sample(16'h0000);
        send_sample(16'hffff);
        send_sample(16'h0001);
        send_sample(16'h8000);
        send_sample(16'h7fff);
        send_sample(16'h1234);
        wait_idle();
    endtask

    task automatic test_window_limits();
        // zero window acts as one, oversized window clamps, alpha clamps at 1.0
        set_config(4'd0, 9'd256);
        send_sample(16'h8000);
        send_sample(16'h7fff);
        wait_idle();
        set_config(4'd15, 9'd0);
        send_sample(16'h0005);
        send_sample(16'hfffb);
        send_sample(16'h8000);
        wait_idle();
        set_config(4'd2, 9'd511);
        send_sample(16'h8000);
        send_sample(16'h7fff);
        send_sample(16'h7fff);
        wait_idle();
        set_config(4'd8, 9'd1);
        send_sample(16'hffff);
        send_sample(16'h0000);
        send_sample(16'h8000);
        send_sample(16'h7ffe);
        wait_idle();
    endtask

    task automatic test_backpressure_fill();
        set_traffic(0, 0);
        hold_len = 200;
        hold_seq++;
        repeat (40) send_sample(rand_sample());
        wait_idle();
    endtask

    task automatic test_random_traffic();
        logic [WL_BITS-1:0]    wl;
        logic [ALPHA_BITS-1:0] a;
        int                    phase;
        int                    blk;
        for (phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0: set_traffic(0, 0);
                1: set_traffic(63, 0);
                2: set_traffic(0, 63);
                default: set_traffic(32, 32);
            endcase
            for (blk = 0; blk < 3; blk++)
            begin
                case ($urandom_range(4))
                    0: wl = 4'd0;
                    1: wl = 4'd15;
                    2: wl = 4'd8;
                    default: wl = WL_BITS'($urandom_range(15));
                endcase
                case ($urandom_range(5))
                    0: a = 9'd0;
                    1: a = 9'd256;
                    2: a = 9'd511;
                    3: a = 9'd255;
                    default: a = ALPHA_BITS'($urandom_range(511));
                endcase
                set_config(wl, a);
                repeat (40) send_sample(rand_sample());
                wait_idle();
            end
        end
    endtask

    always @(posedge clk)
    begin : receiver_stall
        if (hold_seen != hold_seq)
        begin
            hold_seen = hold_seq;
            hold_cnt  = hold_len;
        end
        if (hold_cnt > 0)
        begin
            hold_cnt--;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(99) < out_stall_pct);
    end

    always @(posedge clk)
    begin : result_check
        filt_out_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_filtered.size() == 0)
            begin
                err_cnt++;
                $display("%0t unexpected beat: median %0d smoothed %0d", $time,
                         $signed(median_value), $signed(smoothed_value));
            end
            else
            begin
                want = pending_filtered.pop_front();
                if (median_value !== want.median)
                begin
                    err_cnt++;
                    $display("%0t median_value mismatch: expected %0d actual %0d", $time,
                             $signed(want.median), $signed(median_value));
                end
                if (smoothed_value !== want.smooth)
                begin
                    err_cnt++;
                    $display("%0t smoothed_value mismatch: expected %0d actual %0d", $time,
                             $signed(want.smooth), $signed(smoothed_value));
                end
            end
        end
    end

    always @(posedge clk)
    begin : watchdog
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_defaults();
        test_window_limits();
        test_backpressure_fill();
        test_random_traffic();
        wait_idle();
        if (err_cnt == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
